### src/cbm_pkg.sv
`default_nettype none
package cbm_pkg;

  localparam int ROM_ADDR_BITS_DEF = 23;
  localparam int RAM_ADDR_BITS_DEF = 17;
  localparam int CFG_ADDR_W        = 4;
  localparam int CFG_DATA_W        = 32;

  // mapper kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MBC1 = 3'd1;
  localparam logic [2:0] KIND_MBC2 = 3'd2;
  localparam logic [2:0] KIND_MBC3 = 3'd3;
  localparam logic [2:0] KIND_MBC5 = 3'd4;

  // result targets
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_ROM  = 3'd1;
  localparam logic [2:0] TGT_RAM  = 3'd2;
  localparam logic [2:0] TGT_NIB  = 3'd3;
  localparam logic [2:0] TGT_BOOT = 3'd4;
  localparam logic [2:0] TGT_OPEN = 3'd5;

  // access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_MAPPER_KIND   = 2'd0;
  localparam logic [1:0] REG_ROM_BANK_BITS = 2'd1;
  localparam logic [1:0] REG_COLOUR_MODE   = 2'd2;

  localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
  localparam logic [7:0]  RAM_EN_KEY    = 8'h0A;
  localparam logic [3:0]  RAM_BANK_MAX  = 4'h7;
  localparam logic [3:0]  RTC_SEL_MAX   = 4'hC;
  localparam logic [3:0]  BANK_BITS_MIN = 4'd1;
  localparam logic [3:0]  BANK_BITS_MAX = 4'd9;
  localparam logic [3:0]  SMALL_BITS    = 4'd5;

  typedef struct packed {
    logic [2:0] mapper_kind;
    logic [3:0] rom_bank_bits;
    logic       colour_mode;
  } cfg_t;

  typedef struct packed {
    logic       ram_on;
    logic [8:0] rom_bank;
    logic [3:0] ram_bank;
    logic       bank_mode;
    logic       rtc_mapped;
    logic       boot_done;
  } mst_t;

  typedef struct packed {
    logic        func;
    logic [15:0] bus_addr;
    logic [7:0]  wdata;
    logic        dma_busy;
  } req_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [22:0] mem_addr;
    logic [7:0]  ram_wdata;
    logic        ram_we;
  } rsp_t;

endpackage
`default_nettype wire

### src/cbm_if.sv
`default_nettype none
interface cbm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] bus_addr;
  logic [7:0]  wdata;
  logic        dma_busy;

  modport source (output valid, output func, output bus_addr, output wdata,
                  output dma_busy, input ready);
  modport sink (input valid, input func, input bus_addr, input wdata,
                input dma_busy, output ready);
endinterface

interface cbm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [22:0] mem_addr;
  logic [7:0]  ram_wdata;
  logic        ram_we;

  modport source (output valid, output target, output mem_addr, output ram_wdata,
                  output ram_we, input ready);
  modport sink (input valid, input target, input mem_addr, input ram_wdata,
                input ram_we, output ready);
endinterface
`default_nettype wire

### src/cartridge_bank_mapper_core.sv
// cartridge bank mapper: translates one cpu bus access per cycle, barring output stalls,
// into a target (boot rom, cartridge rom, external ram, ram low nibble, open bus or none)
// and a physical address, and keeps the mbc1/mbc2/mbc3/mbc5 bank registers that bus
// writes program. an access passes the input register, then the result register; one
// access is accepted every cycle unless stalled, and register updates made by a write are
// seen by the very next access. throughput is set by the single combinational translation
// stage between them. set the mapper kind, rom bank count and colour mode through the
// apb-style port only while no access is in flight; the block does not enforce it.
`default_nettype none
module cartridge_bank_mapper_core #(
  parameter int ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF,
  parameter int RAM_ADDR_BITS = cbm_pkg::RAM_ADDR_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  cbm_in_if.sink                         in_ch,
  cbm_out_if.source                      out_ch,
  input  wire                            cfg_psel,
  input  wire                            cfg_penable,
  input  wire                            cfg_pwrite,
  input  wire [cbm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire [cbm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [cbm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  cbm_pkg::cfg_t cfg_r;
  cbm_pkg::mst_t st_r;
  cbm_pkg::mst_t st_nxt;
  cbm_pkg::req_t s1_req_r;
  cbm_pkg::rsp_t out_rsp_r;
  cbm_pkg::rsp_t rsp_nxt;
  logic          s1_v_r;
  logic          out_v_r;
  logic          out_take;
  logic          s1_adv;
  logic          in_xfer;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    case (cfg_idx)
      cbm_pkg::REG_MAPPER_KIND:   cfg_prdata = {29'd0, cfg_r.mapper_kind};
      cbm_pkg::REG_ROM_BANK_BITS: cfg_prdata = {28'd0, cfg_r.rom_bank_bits};
      cbm_pkg::REG_COLOUR_MODE:   cfg_prdata = {31'd0, cfg_r.colour_mode};
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mapper_kind   <= cbm_pkg::KIND_NONE;
      cfg_r.rom_bank_bits <= cbm_pkg::BANK_BITS_MIN;
      cfg_r.colour_mode   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cbm_pkg::REG_MAPPER_KIND:   cfg_r.mapper_kind   <= cfg_pwdata[2:0];
        cbm_pkg::REG_ROM_BANK_BITS: cfg_r.rom_bank_bits <= cfg_pwdata[3:0];
        cbm_pkg::REG_COLOUR_MODE:   cfg_r.colour_mode   <= cfg_pwdata[0];
        default:                    cfg_r               <= cfg_r;
      endcase
    end
  end

  // two-register pipeline with flow control
  assign out_take     = !out_v_r || out_ch.ready;
  assign s1_adv       = s1_v_r && out_take;
  assign in_ch.ready  = !s1_v_r || out_take;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r.func     <= in_ch.func;
      s1_req_r.bus_addr <= in_ch.bus_addr;
      s1_req_r.wdata    <= in_ch.wdata;
      s1_req_r.dma_busy <= in_ch.dma_busy;
    end
  end

  cbm_xlate #(
    .ROM_ADDR_BITS (ROM_ADDR_BITS),
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_xlate (
    .cfg    (cfg_r),
    .st     (st_r),
    .req    (s1_req_r),
    .st_upd (st_nxt),
    .rsp    (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.target    = out_rsp_r.target;
  assign out_ch.mem_addr  = out_rsp_r.mem_addr;
  assign out_ch.ram_wdata = out_rsp_r.ram_wdata;
  assign out_ch.ram_we    = out_rsp_r.ram_we;

endmodule
`default_nettype wire

### src/cbm_xlate.sv
`default_nettype none
module cbm_xlate #(
  parameter int ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF,
  parameter int RAM_ADDR_BITS = cbm_pkg::RAM_ADDR_BITS_DEF
) (
  input  var cbm_pkg::cfg_t cfg,
  input  var cbm_pkg::mst_t st,
  input  var cbm_pkg::req_t req,
  output cbm_pkg::mst_t     st_upd,
  output cbm_pkg::rsp_t     rsp
);

  localparam logic [22:0] ROM_MASK = 23'((64'd1 << ROM_ADDR_BITS) - 64'd1);
  localparam logic [16:0] RAM_MASK = 17'((64'd1 << RAM_ADDR_BITS) - 64'd1);

  logic [3:0]  bits;
  logic [8:0]  cnt_mask;
  logic [4:0]  r5;
  logic [8:0]  sbank;
  logic [8:0]  sw_bank;
  logic        big_rom;
  logic [15:0] a;
  logic [3:0]  lo;
  logic        is_rom;
  logic        is_ram;
  logic        lo_area;
  logic        boot;
  logic [16:0] bank_ram_addr;
  logic [16:0] mbc1_ram_addr;
  logic [22:0] fixed_addr;
  logic [22:0] sw_addr;
  logic        store;
  logic [16:0] store_addr;

  always_comb begin
    if (cfg.rom_bank_bits < cbm_pkg::BANK_BITS_MIN) begin
      bits = cbm_pkg::BANK_BITS_MIN;
    end else if (cfg.rom_bank_bits > cbm_pkg::BANK_BITS_MAX) begin
      bits = cbm_pkg::BANK_BITS_MAX;
    end else begin
      bits = cfg.rom_bank_bits;
    end
    cnt_mask = ~(9'h1FF << bits);
    big_rom  = bits > cbm_pkg::SMALL_BITS;
    r5       = (st.rom_bank[4:0] == 5'd0) ? 5'd1 : st.rom_bank[4:0];
    if (big_rom) begin
      sbank = {2'd0, st.ram_bank[1:0], r5} & cnt_mask;
    end else begin
      sbank = {4'd0, r5} & cnt_mask;
    end

    a       = req.bus_addr;
    lo      = req.wdata[3:0];
    is_rom  = !a[15];
    is_ram  = a[15:13] == 3'b101;
    lo_area = a[15:14] == 2'b00;
    boot    = !st.boot_done && (a < 16'h0100 ||
              (cfg.colour_mode && a >= 16'h0200 && a < 16'h0900));

    bank_ram_addr = {st.ram_bank, a[12:0]};
    mbc1_ram_addr = st.bank_mode ? {2'd0, st.ram_bank[1:0], a[12:0]} : {4'd0, a[12:0]};

    if (cfg.mapper_kind == cbm_pkg::KIND_MBC1 || cfg.mapper_kind == cbm_pkg::KIND_MBC2) begin
      sw_bank = sbank;
    end else begin
      sw_bank = st.rom_bank;
    end
    sw_addr = {sw_bank, a[13:0]} & ROM_MASK;
    if (cfg.mapper_kind == cbm_pkg::KIND_MBC1 && big_rom && st.bank_mode) begin
      fixed_addr = {2'd0, st.ram_bank[1:0], 5'd0, a[13:0]} & ROM_MASK;
    end else begin
      fixed_addr = {9'd0, a[13:0]} & ROM_MASK;
    end

    st_upd     = st;
    rsp        = '0;
    store      = 1'b0;
    store_addr = '0;

    if (req.func == cbm_pkg::FUNC_READ) begin
      if (is_rom || is_ram) begin
        if (cfg.mapper_kind > cbm_pkg::KIND_MBC5) begin
          rsp.target = cbm_pkg::TGT_OPEN;
        end else if (lo_area && boot) begin
          rsp.target   = cbm_pkg::TGT_BOOT;
          rsp.mem_addr = {7'd0, a};
        end else if (cfg.mapper_kind == cbm_pkg::KIND_NONE) begin
          if (is_rom) begin
            rsp.target   = cbm_pkg::TGT_ROM;
            rsp.mem_addr = {7'd0, a} & ROM_MASK;
          end else begin
            rsp.target   = cbm_pkg::TGT_RAM;
            rsp.mem_addr = {10'd0, a[12:0]} & {6'd0, RAM_MASK};
          end
        end else if (lo_area) begin
          rsp.target   = cbm_pkg::TGT_ROM;
          rsp.mem_addr = fixed_addr;
        end else if (is_rom) begin
          rsp.target   = cbm_pkg::TGT_ROM;
          rsp.mem_addr = sw_addr;
        end else begin
          case (cfg.mapper_kind)
            cbm_pkg::KIND_MBC1: begin
              if (!st.ram_on) begin
                rsp.target = cbm_pkg::TGT_OPEN;
              end else begin
                rsp.target   = cbm_pkg::TGT_RAM;
                rsp.mem_addr = {6'd0, mbc1_ram_addr & RAM_MASK};
              end
            end
            cbm_pkg::KIND_MBC2: begin
              if (!st.ram_on) begin
                rsp.target = cbm_pkg::TGT_OPEN;
              end else begin
                rsp.target   = cbm_pkg::TGT_NIB;
                rsp.mem_addr = {14'd0, a[8:0]} & {6'd0, RAM_MASK};
              end
            end
            cbm_pkg::KIND_MBC3: begin
              if (st.rtc_mapped) begin
                rsp.target = cbm_pkg::TGT_OPEN;
              end else begin
                rsp.target   = cbm_pkg::TGT_RAM;
                rsp.mem_addr = {6'd0, bank_ram_addr & RAM_MASK};
              end
            end
            default: begin
              if (!st.ram_on) begin
                rsp.target = cbm_pkg::TGT_OPEN;
              end else begin
                rsp.target   = cbm_pkg::TGT_RAM;
                rsp.mem_addr = {6'd0, bank_ram_addr & RAM_MASK};
              end
            end
          endcase
        end
      end
    end else begin
      if (a == cbm_pkg::BOOT_OFF_ADDR) begin
        st_upd.boot_done = 1'b1;
      end
      case (cfg.mapper_kind)
        cbm_pkg::KIND_NONE: begin
          if (is_ram && !req.dma_busy) begin
            store      = 1'b1;
            store_addr = {4'd0, a[12:0]};
          end
        end
        cbm_pkg::KIND_MBC1: begin
          if (a <= 16'h1FFF) begin
            st_upd.ram_on = req.wdata == cbm_pkg::RAM_EN_KEY;
          end else if (a <= 16'h3FFF) begin
            st_upd.rom_bank = {4'd0, req.wdata[4:0]};
          end else if (a <= 16'h5FFF) begin
            st_upd.ram_bank = {2'd0, req.wdata[1:0]};
          end else if (a <= 16'h7FFF) begin
            st_upd.bank_mode = req.wdata[0];
          end else if (is_ram && !req.dma_busy && st.ram_on) begin
            store      = 1'b1;
            store_addr = mbc1_ram_addr;
          end
        end
        cbm_pkg::KIND_MBC2: begin
          if (a <= 16'h3FFF) begin
            if (!a[8]) begin
              st_upd.ram_on = lo == cbm_pkg::RAM_EN_KEY[3:0] && req.wdata[7:4] == 4'd0 ?
                              1'b1 : (lo == cbm_pkg::RAM_EN_KEY[3:0]);
            end else begin
              st_upd.rom_bank = {5'd0, lo};
            end
          end
        end
        cbm_pkg::KIND_MBC3: begin
          if (a <= 16'h1FFF) begin
            st_upd.ram_on = req.wdata == cbm_pkg::RAM_EN_KEY;
          end else if (a <= 16'h3FFF) begin
            st_upd.rom_bank = (req.wdata == 8'd0) ? 9'd1 : {1'b0, req.wdata};
          end else if (a <= 16'h5FFF) begin
            if (lo <= cbm_pkg::RAM_BANK_MAX) begin
              st_upd.rtc_mapped = 1'b0;
              st_upd.ram_bank   = lo;
            end else if (lo <= cbm_pkg::RTC_SEL_MAX) begin
              st_upd.rtc_mapped = 1'b1;
            end else begin
              st_upd.rtc_mapped = 1'b0;
            end
          end else if (is_ram && !req.dma_busy) begin
            store      = 1'b1;
            store_addr = bank_ram_addr;
          end
        end
        cbm_pkg::KIND_MBC5: begin
          if (a <= 16'h1FFF) begin
            st_upd.ram_on = req.wdata == cbm_pkg::RAM_EN_KEY;
          end else if (a <= 16'h2FFF) begin
            st_upd.rom_bank = {st.rom_bank[8], req.wdata};
          end else if (a <= 16'h3FFF) begin
            st_upd.rom_bank = {req.wdata[0], st.rom_bank[7:0]};
          end else if (a <= 16'h5FFF) begin
            st_upd.ram_bank = lo;
          end else if (is_ram && !req.dma_busy) begin
            store      = 1'b1;
            store_addr = bank_ram_addr;
          end
        end
        default: begin
          store = 1'b0;
        end
      endcase
      if (store) begin
        rsp.target    = cbm_pkg::TGT_RAM;
        rsp.mem_addr  = {6'd0, store_addr & RAM_MASK};
        rsp.ram_wdata = req.wdata;
        rsp.ram_we    = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### test/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  KIND_UNKNOWN_LO = 3'd5;
  localparam logic [2:0]  KIND_UNKNOWN_HI = 3'd7;
  localparam int unsigned IDLE_LIMIT      = 2000;

  class mapper_scoreboard;
    localparam int unsigned ROM_MASK = (32'd1 << cbm_pkg::ROM_ADDR_BITS_DEF) - 1;
    localparam int unsigned RAM_MASK = (32'd1 << cbm_pkg::RAM_ADDR_BITS_DEF) - 1;

    cbm_pkg::cfg_t cfg;
    cbm_pkg::mst_t st;
    cbm_pkg::rsp_t xlat_q[$];
    int unsigned   errors;

    function new();
      cfg.mapper_kind   = cbm_pkg::KIND_NONE;
      cfg.rom_bank_bits = cbm_pkg::BANK_BITS_MIN;
      cfg.colour_mode   = 1'b0;
      st                = '0;
      errors            = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        cbm_pkg::REG_MAPPER_KIND:   cfg.mapper_kind = val[2:0];
        cbm_pkg::REG_ROM_BANK_BITS: cfg.rom_bank_bits = val[3:0];
        cbm_pkg::REG_COLOUR_MODE:   cfg.colour_mode = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return xlat_q.size();
    endfunction

    function logic [22:0] rom_lim(int unsigned x);
      return 23'(x & ROM_MASK);
    endfunction

    function logic [22:0] ram_lim(int unsigned x);
      return 23'(x & RAM_MASK);
    endfunction

    function int unsigned eff_bits();
      if (cfg.rom_bank_bits < cbm_pkg::BANK_BITS_MIN) return 32'(cbm_pkg::BANK_BITS_MIN);
      if (cfg.rom_bank_bits > cbm_pkg::BANK_BITS_MAX) return 32'(cbm_pkg::BANK_BITS_MAX);
      return 32'(cfg.rom_bank_bits);
    endfunction

    function bit in_boot(logic [15:0] a);
      if (st.boot_done) return 1'b0;
      if (a < 16'h0100) return 1'b1;
      return cfg.colour_mode && a >= 16'h0200 && a < 16'h0900;
    endfunction

    // mbc1/mbc2 switchable bank, wrapped to the bank count
    function int unsigned switch_bank();
      int unsigned bits;
      int unsigned cnt_mask;
      int unsigned low5;
      bits     = eff_bits();
      cnt_mask = (32'd1 << bits) - 1;
      low5     = 32'(st.rom_bank[4:0]);
      if (low5 == 0) low5 = 1;
      if (bits <= 32'(cbm_pkg::SMALL_BITS)) return low5 & cnt_mask;
      return ((int'(st.ram_bank[1:0]) << 5) | low5) & cnt_mask;
    endfunction

    function cbm_pkg::rsp_t predict_read(logic [15:0] a);
      cbm_pkg::rsp_t r;
      int unsigned   off14;
      int unsigned   off13;
      int unsigned   bank;
      bit            is_rom;
      bit            is_ram;
      r      = '0;
      off14  = 32'(a & 16'h3FFF);
      off13  = 32'(a & 16'h1FFF);
      is_rom = (a < 16'h8000);
      is_ram = (a >= 16'hA000 && a <= 16'hBFFF);
      if (!is_rom && !is_ram) return r;
      if (cfg.mapper_kind > cbm_pkg::KIND_MBC5) begin
        r.target = cbm_pkg::TGT_OPEN;
        return r;
      end
      if (is_rom && a < 16'h4000 && in_boot(a)) begin
        r.target   = cbm_pkg::TGT_BOOT;
        r.mem_addr = 23'(a);
        return r;
      end
      if (cfg.mapper_kind == cbm_pkg::KIND_NONE) begin
        if (is_rom) begin
          r.target   = cbm_pkg::TGT_ROM;
          r.mem_addr = rom_lim(32'(a));
        end else begin
          r.target   = cbm_pkg::TGT_RAM;
          r.mem_addr = ram_lim(32'(a - 16'hA000));
        end
        return r;
      end
      if (is_rom && a < 16'h4000) begin
        bank = 0;
        if (cfg.mapper_kind == cbm_pkg::KIND_MBC1 && eff_bits() > 32'(cbm_pkg::SMALL_BITS) &&
            st.bank_mode)
          bank = 32'(st.ram_bank[1:0]);
        r.target   = cbm_pkg::TGT_ROM;
        r.mem_addr = rom_lim((bank << 19) | off14);
        return r;
      end
      if (is_rom) begin
        bank       = (cfg.mapper_kind <= cbm_pkg::KIND_MBC2) ? switch_bank() :
                     32'(st.rom_bank);
        r.target   = cbm_pkg::TGT_ROM;
        r.mem_addr = rom_lim((bank << 14) | off14);
        return r;
      end
      case (cfg.mapper_kind)
        cbm_pkg::KIND_MBC1: begin
          if (!st.ram_on) r.target = cbm_pkg::TGT_OPEN;
          else begin
            r.target   = cbm_pkg::TGT_RAM;
            r.mem_addr = ram_lim(st.bank_mode ? ((int'(st.ram_bank[1:0]) << 13) | off13)
                                              : off13);
          end
        end
        cbm_pkg::KIND_MBC2: begin
          if (!st.ram_on) r.target = cbm_pkg::TGT_OPEN;
          else begin
            r.target   = cbm_pkg::TGT_NIB;
            r.mem_addr = ram_lim(32'(a & 16'h01FF));
          end
        end
        cbm_pkg::KIND_MBC3: begin
          if (st.rtc_mapped) r.target = cbm_pkg::TGT_OPEN;
          else begin
            r.target   = cbm_pkg::TGT_RAM;
            r.mem_addr = ram_lim((int'(st.ram_bank) << 13) | off13);
          end
        end
        default: begin
          if (!st.ram_on) r.target = cbm_pkg::TGT_OPEN;
          else begin
            r.target   = cbm_pkg::TGT_RAM;
            r.mem_addr = ram_lim((int'(st.ram_bank) << 13) | off13);
          end
        end
      endcase
      return r;
    endfunction

    function cbm_pkg::rsp_t predict_write(logic [15:0] a, logic [7:0] v, logic dma);
      cbm_pkg::rsp_t r;
      bit            is_ram;
      bit            store;
      int unsigned   off13;
      int unsigned   ma;
      logic [3:0]    lo;
      r      = '0;
      store  = 1'b0;
      ma     = 0;
      is_ram = (a >= 16'hA000 && a <= 16'hBFFF);
      off13  = 32'(a & 16'h1FFF);
      lo     = v[3:0];
      if (a == cbm_pkg::BOOT_OFF_ADDR) st.boot_done = 1'b1;
      case (cfg.mapper_kind)
        cbm_pkg::KIND_NONE: begin
          if (is_ram && !dma) begin
            ma    = 32'(a - 16'hA000);
            store = 1'b1;
          end
        end
        cbm_pkg::KIND_MBC1: begin
          if (a <= 16'h1FFF) st.ram_on = (v == cbm_pkg::RAM_EN_KEY);
          else if (a <= 16'h3FFF) st.rom_bank = {4'd0, v[4:0]};
          else if (a <= 16'h5FFF) st.ram_bank = {2'd0, v[1:0]};
          else if (a <= 16'h7FFF) st.bank_mode = v[0];
          else if (is_ram && !dma && st.ram_on) begin
            ma    = st.bank_mode ? ((int'(st.ram_bank[1:0]) << 13) | off13) : off13;
            store = 1'b1;
          end
        end
        cbm_pkg::KIND_MBC2: begin
          if (a <= 16'h3FFF) begin
            if (!a[8]) st.ram_on = (lo == cbm_pkg::RAM_EN_KEY[3:0]);
            else st.rom_bank = {5'd0, lo};
          end
        end
        cbm_pkg::KIND_MBC3: begin
          if (a <= 16'h1FFF) st.ram_on = (v == cbm_pkg::RAM_EN_KEY);
          else if (a <= 16'h3FFF) st.rom_bank = (v == 8'd0) ? 9'd1 : {1'b0, v};
          else if (a <= 16'h5FFF) begin
            if (lo <= cbm_pkg::RAM_BANK_MAX) begin
              st.rtc_mapped = 1'b0;
              st.ram_bank   = lo;
            end else if (lo <= cbm_pkg::RTC_SEL_MAX) st.rtc_mapped = 1'b1;
            else st.rtc_mapped = 1'b0;
          end else if (is_ram && !dma) begin
            ma    = (int'(st.ram_bank) << 13) | off13;
            store = 1'b1;
          end
        end
        cbm_pkg::KIND_MBC5: begin
          if (a <= 16'h1FFF) st.ram_on = (v == cbm_pkg::RAM_EN_KEY);
          else if (a <= 16'h2FFF) st.rom_bank = {st.rom_bank[8], v};
          else if (a <= 16'h3FFF) st.rom_bank = {v[0], st.rom_bank[7:0]};
          else if (a <= 16'h5FFF) st.ram_bank = lo;
          else if (is_ram && !dma) begin
            ma    = (int'(st.ram_bank) << 13) | off13;
            store = 1'b1;
          end
        end
        default: ;
      endcase
      if (store) begin
        r.target    = cbm_pkg::TGT_RAM;
        r.mem_addr  = ram_lim(ma);
        r.ram_wdata = v;
        r.ram_we    = 1'b1;
      end
      return r;
    endfunction

    function void note_access(cbm_pkg::req_t q);
      if (q.func == cbm_pkg::FUNC_READ) xlat_q.push_back(predict_read(q.bus_addr));
      else xlat_q.push_back(predict_write(q.bus_addr, q.wdata, q.dma_busy));
    endfunction

    function void flag(string what, cbm_pkg::rsp_t exp, cbm_pkg::rsp_t got);
      errors++;
      if (errors <= 10)
        $display("%s: exp tgt %0d addr %h wd %h we %0d, got tgt %0d addr %h wd %h we %0d",
                 what, exp.target, exp.mem_addr, exp.ram_wdata, exp.ram_we,
                 got.target, got.mem_addr, got.ram_wdata, got.ram_we);
    endfunction

    function void check_result(cbm_pkg::rsp_t got);
      cbm_pkg::rsp_t exp;
      if (xlat_q.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      exp = xlat_q.pop_front();
      if (got.target !== exp.target || got.mem_addr !== exp.mem_addr ||
          got.ram_wdata !== exp.ram_wdata || got.ram_we !== exp.ram_we)
        flag("mismatch", exp, got);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [cbm_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;
  bit          calm;
  int unsigned idle_cycles = 0;

  mapper_scoreboard sb = new();

  cbm_in_if  in_ch();
  cbm_out_if out_ch();

  cartridge_bank_mapper_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] rand_addr(bit allow_end);
    int unsigned r;
    logic [15:0] a;
    r = $urandom_range(0, 99);
    if (r < 6) a = 16'($urandom_range(0, 16'h08FF));
    else if (r < 30) a = 16'($urandom_range(0, 16'h3FFF));
    else if (r < 55) a = 16'($urandom_range(16'h4000, 16'h7FFF));
    else if (r < 85) a = 16'($urandom_range(16'hA000, 16'hBFFF));
    else if (r < 94) a = 16'($urandom_range(16'h8000, 16'hFFFF));
    else begin
      case ($urandom_range(0, 12))
        0: a = 16'h0000;
        1: a = 16'h1FFF;
        2: a = 16'h2000;
        3: a = 16'h2FFF;
        4: a = 16'h3000;
        5: a = 16'h3FFF;
        6: a = 16'h4000;
        7: a = 16'h5FFF;
        8: a = 16'h6000;
        9: a = 16'h7FFF;
        10: a = 16'hBFFF;
        11: a = 16'h0100;
        default: a = cbm_pkg::BOOT_OFF_ADDR;
      endcase
    end
    if (!allow_end && a == cbm_pkg::BOOT_OFF_ADDR) a = a + 16'd1;
    return a;
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return cbm_pkg::RAM_EN_KEY;
    if (r < 35) return 8'h00;
    if (r < 45) return 8'hFF;
    if (r < 60) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic cbm_pkg::req_t mk_access(logic func, logic [15:0] a, logic [7:0] v,
                                              logic dma);
    cbm_pkg::req_t q;
    q.func     = func;
    q.bus_addr = a;
    q.wdata    = v;
    q.dma_busy = dma;
    return q;
  endfunction

  function automatic cbm_pkg::req_t rand_access(bit allow_end);
    return mk_access(($urandom_range(0, 99) < 45) ? cbm_pkg::FUNC_WRITE : cbm_pkg::FUNC_READ,
                     rand_addr(allow_end), rand_byte(), $urandom_range(0, 3) == 0);
  endfunction

  task automatic send_access(input cbm_pkg::req_t q);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1)) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= q.func;
    in_ch.bus_addr <= q.bus_addr;
    in_ch.wdata    <= q.wdata;
    in_ch.dma_busy <= q.dma_busy;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [2:0] kind, input logic [3:0] bits, input logic colour);
    logic [31:0] vals[3];
    logic [1:0]  idx[3];
    vals = '{32'(kind), 32'(bits), 32'(colour)};
    idx  = '{cbm_pkg::REG_MAPPER_KIND, cbm_pkg::REG_ROM_BANK_BITS, cbm_pkg::REG_COLOUR_MODE};
    for (int i = 0; i < 3; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {idx[i], 2'b00};
      cfg_pwdata  <= vals[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [2:0] kind, input logic [3:0] bits, input logic colour,
                           input int unsigned n, input bit allow_end, input bit end_boot);
    apply_cfg(kind, bits, colour);
    calm = ($urandom_range(0, 3) == 0);
    if (end_boot) begin
      send_access(mk_access(cbm_pkg::FUNC_WRITE, cbm_pkg::BOOT_OFF_ADDR, 8'h01, 1'b0));
      send_access(mk_access(cbm_pkg::FUNC_READ, 16'h0000, 8'h00, 1'b0));
    end
    repeat (n) send_access(rand_access(allow_end));
    drain();
  endtask

  // result side stalls
  initial begin
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cbm_pkg::req_t acc;
    cbm_pkg::rsp_t res;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        acc.func     = in_ch.func;
        acc.bus_addr = in_ch.bus_addr;
        acc.wdata    = in_ch.wdata;
        acc.dma_busy = in_ch.dma_busy;
        sb.note_access(acc);
      end
      if (out_ch.valid && out_ch.ready) begin
        res.target    = out_ch.target;
        res.mem_addr  = out_ch.mem_addr;
        res.ram_wdata = out_ch.ram_wdata;
        res.ram_we    = out_ch.ram_we;
        sb.check_result(res);
      end
    end
  end

  // ends the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("[cartridge_bank_mapper_core] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    calm           = 1'b0;
    rst_n          <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= cbm_pkg::FUNC_READ;
    in_ch.bus_addr <= '0;
    in_ch.wdata    <= '0;
    in_ch.dma_busy <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // boot overlay edges, area limits and plain ram stores
    apply_cfg(cbm_pkg::KIND_NONE, 4'd1, 1'b1);
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h0000, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h00FF, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h0100, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h0200, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h08FF, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h0900, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h3FFF, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h4000, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h7FFF, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h8000, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'h9FFF, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'hA000, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'hBFFF, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'hC000, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_READ, 16'hFFFF, 8'hFF, 1'b1));
    send_access(mk_access(cbm_pkg::FUNC_WRITE, 16'hA000, 8'h00, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_WRITE, 16'hBFFF, 8'hFF, 1'b0));
    send_access(mk_access(cbm_pkg::FUNC_WRITE, 16'hBFFF, 8'hFF, 1'b1));
    send_access(mk_access(cbm_pkg::FUNC_WRITE, 16'h0000, 8'hFF, 1'b1));
    send_access(mk_access(cbm_pkg::FUNC_WRITE, 16'hFFFF, 8'hA5, 1'b0));
    drain();

    // boot overlay stays on for the first two phases
    run_phase(cbm_pkg::KIND_MBC1, 4'd6, 1'b1, 50, 1'b0, 1'b0);
    run_phase(cbm_pkg::KIND_MBC3, 4'd7, 1'b0, 40, 1'b0, 1'b0);
    run_phase(cbm_pkg::KIND_MBC1, 4'd9, 1'b0, 60, 1'b1, 1'b1);
    run_phase(cbm_pkg::KIND_MBC1, 4'd5, 1'b0, 35, 1'b1, 1'b0);
    run_phase(cbm_pkg::KIND_MBC1, 4'd1, 1'b1, 25, 1'b1, 1'b0);
    run_phase(cbm_pkg::KIND_MBC2, 4'd4, 1'b0, 45, 1'b1, 1'b0);
    run_phase(cbm_pkg::KIND_MBC2, 4'd8, 1'b1, 35, 1'b1, 1'b0);
    run_phase(cbm_pkg::KIND_MBC3, 4'd9, 1'b0, 55, 1'b1, 1'b0);
    run_phase(cbm_pkg::KIND_MBC5, 4'd9, 1'b0, 65, 1'b1, 1'b0);
    run_phase(cbm_pkg::KIND_MBC5, 4'd0, 1'b1, 25, 1'b1, 1'b0);
    run_phase(cbm_pkg::KIND_NONE, 4'd15, 1'b0, 25, 1'b1, 1'b0);
    run_phase(KIND_UNKNOWN_HI, 4'd3, 1'b0, 15, 1'b1, 1'b0);
    run_phase(KIND_UNKNOWN_LO, 4'd2, 1'b1, 15, 1'b1, 1'b0);
    run_phase(cbm_pkg::KIND_MBC1, 4'd15, 1'b1, 30, 1'b1, 1'b0);

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[cartridge_bank_mapper_core] OK");
    else
      $display("[cartridge_bank_mapper_core] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
